FILE: rtl/alkd_pkg.sv
// Package for the ADC ladder key decoder: field widths, key codes and the
// two board threshold and key-code tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alkd_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int CODE_W      = 3;
  localparam int KEY_W       = 8;
  localparam int COUNT_W     = 3;
  localparam int NUM_LEVELS  = 6;
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);

  localparam logic [KEY_W-1:0]   KEY_LOCKED    = 8'hff;
  localparam logic [KEY_W-1:0]   KEY_NONE      = 8'h00;
  localparam logic [CODE_W-1:0]  CODE_CLEAR    = 3'd3;
  localparam logic [CODE_W-1:0]  CODE_COMPOUND = 3'd4;
  localparam logic [COUNT_W-1:0] COMPOUND_MAX  = 3'd3;

  typedef enum logic {
    BOARD_FIRST  = 1'b0,
    BOARD_SECOND = 1'b1
  } board_t;

  // no-key limit equals the first threshold of each table
  function automatic logic [SAMPLE_W-1:0] limit_of(input board_t board);
    logic [SAMPLE_W-1:0] lim;
    unique case (board)
      BOARD_FIRST:  lim = 8'd92;
      BOARD_SECOND: lim = 8'd190;
      default:      lim = 8'd92;
    endcase
    return lim;
  endfunction

  function automatic logic [SAMPLE_W-1:0] thr_of(input board_t board,
                                                 input logic [SLOT_W-1:0] slot);
    logic [SAMPLE_W-1:0] thr;
    thr = 8'd255;
    if (board == BOARD_FIRST) begin
      unique case (slot)
        4'd0:    thr = 8'd92;
        4'd1:    thr = 8'd72;
        4'd2:    thr = 8'd52;
        4'd3:    thr = 8'd33;
        4'd4:    thr = 8'd12;
        4'd5:    thr = 8'd0;
        default: thr = 8'd255;
      endcase
    end else begin
      unique case (slot)
        4'd0:    thr = 8'd190;
        4'd1:    thr = 8'd164;
        4'd2:    thr = 8'd148;
        4'd3:    thr = 8'd134;
        4'd4:    thr = 8'd120;
        4'd5:    thr = 8'd106;
        default: thr = 8'd255;
      endcase
    end
    return thr;
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input board_t board,
                                                input logic [SLOT_W-1:0] slot);
    logic [CODE_W-1:0] code;
    code = 3'd0;
    if (board == BOARD_FIRST) begin
      unique case (slot)
        4'd1:    code = 3'd3;
        4'd2:    code = 3'd1;
        4'd3:    code = 3'd2;
        4'd5:    code = 3'd4;
        default: code = 3'd0;
      endcase
    end else begin
      unique case (slot)
        4'd1:    code = 3'd4;
        4'd2:    code = 3'd3;
        4'd3:    code = 3'd2;
        4'd4:    code = 3'd1;
        default: code = 3'd0;
      endcase
    end
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/adc_ladder_key_decoder.sv
// Resistor-ladder keypad decoder: input register, one pass of decode logic,
// result register. Depends on alkd_pkg.
//
// Usage:
//   Slave stream: s_axis_tdata carries the 8-bit ADC sample, s_axis_tuser the
//   blanking flag; a blanked sample leaves the key state alone and only
//   reports it. Master stream: one result per request, key_value in the low
//   byte of m_axis_tdata, then clear_error and locked.
//   cfg_we/cfg_wdata write board_mode (table set and no-key limit); write it
//   only while the block is idle.
//   An accepted request is held in the input register, then decoded into the
//   result register. Throughput: one request per cycle while the receiver
//   takes results, set by the single decode pass between the input register
//   and the result register; the key state updates as the result is loaded,
//   so back-to-back requests see it.
//   Reset clears board_mode, all key state and both stream stages.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, then s_axis_tready drops until the result
//   is taken.
`timescale 1ns / 1ps
`default_nettype none

module adc_ladder_key_decoder
  import alkd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] sample
  input  wire logic        s_axis_tuser,   // [0] blanking
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [7:0] key_value, [8] clear_error,
                                           // [9] locked, [15:10] zero
);

  board_t board_mode;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_blank;

  logic               lock_flag;
  logic [CODE_W-1:0]  previous_code;
  logic [KEY_W-1:0]   confirmed_key;
  logic [KEY_W-1:0]   last_confirmed;
  logic [COUNT_W-1:0] compound_count;

  logic               lock_flag_next;
  logic [CODE_W-1:0]  previous_code_next;
  logic [KEY_W-1:0]   confirmed_key_next;
  logic [KEY_W-1:0]   last_confirmed_next;
  logic [COUNT_W-1:0] compound_count_next;
  logic               pulse_next;

  logic [KEY_W-1:0] key_value;
  logic             clear_error;
  logic             locked;

  logic out_free;
  logic advance;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;

  // decode pass
  always_comb begin
    logic                hit;
    logic [CODE_W-1:0]   hit_code;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                confirm;
    logic [KEY_W-1:0]    key_tmp;
    lock_flag_next      = lock_flag;
    previous_code_next  = previous_code;
    confirmed_key_next  = confirmed_key;
    last_confirmed_next = last_confirmed;
    compound_count_next = compound_count;
    pulse_next          = 1'b0;
    hit                 = 1'b0;
    hit_code            = '0;
    cnt_inc             = compound_count + COUNT_W'(1);
    confirm             = 1'b0;
    key_tmp             = confirmed_key;
    // highest slot first, so the lowest matching slot, checked last, wins
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (s1_sample >= thr_of(board_mode, SLOT_W'(i))) begin
        hit      = 1'b1;
        hit_code = code_of(board_mode, SLOT_W'(i));
      end
    end
    if (!s1_blank) begin
      if (s1_sample >= limit_of(board_mode)) begin
        lock_flag_next      = 1'b0;
        last_confirmed_next = KEY_NONE;
        confirmed_key_next  = KEY_NONE;
        previous_code_next  = '0;
      end else if (!lock_flag && hit) begin
        if (previous_code != hit_code) begin
          previous_code_next = hit_code;
        end else begin
          if (hit_code == CODE_CLEAR || hit_code == CODE_COMPOUND) begin
            if (cnt_inc > COMPOUND_MAX) begin
              compound_count_next = COMPOUND_MAX;
              confirm             = 1'b1;
              pulse_next          = (hit_code == CODE_CLEAR);
            end else begin
              compound_count_next = cnt_inc;
            end
          end else begin
            compound_count_next = '0;
            confirm             = 1'b1;
          end
          if (confirm) begin
            key_tmp = KEY_W'(hit_code);
          end
          if (last_confirmed != KEY_NONE && last_confirmed != key_tmp) begin
            lock_flag_next     = 1'b1;
            confirmed_key_next = KEY_LOCKED;
          end else begin
            confirmed_key_next  = key_tmp;
            last_confirmed_next = key_tmp;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      board_mode     <= BOARD_FIRST;
      s1_valid       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      lock_flag      <= 1'b0;
      previous_code  <= '0;
      confirmed_key  <= KEY_NONE;
      last_confirmed <= KEY_NONE;
      compound_count <= '0;
    end else begin
      if (cfg_we) begin
        board_mode <= board_t'(cfg_wdata);
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        m_axis_tvalid <= s1_valid;
      end
      if (advance) begin
        lock_flag      <= lock_flag_next;
        previous_code  <= previous_code_next;
        confirmed_key  <= confirmed_key_next;
        last_confirmed <= last_confirmed_next;
        compound_count <= compound_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_sample <= s_axis_tdata;
      s1_blank  <= s_axis_tuser;
    end
    if (advance) begin
      key_value   <= confirmed_key_next;
      clear_error <= pulse_next;
      locked      <= lock_flag_next;
    end
  end

  assign m_axis_tdata = {6'b0, locked, clear_error, key_value};

  a_lock_shows_ff: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && locked |-> key_value == KEY_LOCKED)
    else $error("locked result without locked key value");

  a_clear_on_three: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && clear_error |->
      key_value == KEY_W'(CODE_CLEAR) || key_value == KEY_LOCKED)
    else $error("clear_error without key code 3");

  a_state_lock: assert property (@(posedge clk) disable iff (rst)
    lock_flag |-> confirmed_key == KEY_LOCKED)
    else $error("lock flag set with a decoded key");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    compound_count <= COMPOUND_MAX)
    else $error("compound count past its limit");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(confirmed_key) && $stable(lock_flag))
    else $error("key state moved without a decoded request");

endmodule

`default_nettype wire

FILE: test/adc_ladder_key_checker.sv
// Result checker for adc_ladder_key_decoder: tracks the key state from accepted
// requests and compares every result, field by field, in order.
// Depends on alkd_pkg.
`timescale 1ns / 1ps

module adc_ladder_key_checker
  import alkd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          pending,
  output int          errors
);

  typedef struct packed {
    logic             locked;
    logic             clear_error;
    logic [KEY_W-1:0] key_value;
  } key_report_t;

  // first slot of each ladder is also the no-key limit
  localparam logic [0:1][0:NUM_LEVELS-1][SAMPLE_W-1:0] LADDER_THR = {
    8'd92,  8'd72,  8'd52,  8'd33,  8'd12,  8'd0,
    8'd190, 8'd164, 8'd148, 8'd134, 8'd120, 8'd106
  };
  localparam logic [0:1][0:NUM_LEVELS-1][CODE_W-1:0] LADDER_CODE = {
    3'd0, 3'd3, 3'd1, 3'd2, 3'd0, 3'd4,
    3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
  };

  board_t             board;
  logic               lock_held;
  logic [CODE_W-1:0]  prev_code;
  logic [KEY_W-1:0]   held_key;
  logic [KEY_W-1:0]   last_key;
  logic [COUNT_W-1:0] agree_run;
  key_report_t        key_reports_q[$];
  int                 fail_total;

  task automatic decode_sample(input logic [SAMPLE_W-1:0] smp, input logic blank,
                               output key_report_t rep);
    logic              pulse;
    logic              hit;
    logic [CODE_W-1:0] code;
    pulse = 1'b0;
    hit   = 1'b0;
    code  = '0;
    if (!blank) begin
      if (smp >= LADDER_THR[board][0]) begin
        lock_held = 1'b0;
        last_key  = KEY_NONE;
        held_key  = KEY_NONE;
        prev_code = '0;
      end else if (!lock_held) begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (!hit && smp >= LADDER_THR[board][i]) begin
            hit  = 1'b1;
            code = LADDER_CODE[board][i];
          end
        end
        if (hit) begin
          if (prev_code != code) begin
            prev_code = code;
          end else begin
            if (code == CODE_CLEAR || code == CODE_COMPOUND) begin
              agree_run = agree_run + COUNT_W'(1);
              if (agree_run > COMPOUND_MAX) begin
                agree_run = COMPOUND_MAX;
                held_key  = KEY_W'(code);
                if (code == CODE_CLEAR) pulse = 1'b1;
              end
            end else begin
              agree_run = '0;
              held_key  = KEY_W'(code);
            end
            if (last_key != KEY_NONE && last_key != held_key) begin
              lock_held = 1'b1;
              held_key  = KEY_LOCKED;
            end else begin
              last_key = held_key;
            end
          end
        end
      end
    end
    rep.key_value   = held_key;
    rep.clear_error = pulse;
    rep.locked      = lock_held;
  endtask

  always @(posedge clk) begin
    key_report_t rep;
    key_report_t want;
    if (rst) begin
      board      = BOARD_FIRST;
      lock_held  = 1'b0;
      prev_code  = '0;
      held_key   = KEY_NONE;
      last_key   = KEY_NONE;
      agree_run  = '0;
      fail_total = 0;
      key_reports_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rep = key_report_t'(m_axis_tdata[9:0]);
        if (key_reports_q.size() == 0) begin
          $error("result 0x%0h with no request outstanding", m_axis_tdata);
          fail_total++;
        end else begin
          want = key_reports_q.pop_front();
          if (rep.key_value !== want.key_value) begin
            $error("key_value: expected %0d, actual %0d", want.key_value, rep.key_value);
            fail_total++;
          end
          if (rep.clear_error !== want.clear_error) begin
            $error("clear_error: expected %0d, actual %0d", want.clear_error,
                   rep.clear_error);
            fail_total++;
          end
          if (rep.locked !== want.locked) begin
            $error("locked: expected %0d, actual %0d", want.locked, rep.locked);
            fail_total++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_sample(s_axis_tdata, s_axis_tuser, rep);
        key_reports_q.push_back(rep);
      end
      if (cfg_we) board = board_t'(cfg_wdata);
    end
    pending <= key_reports_q.size();
    errors  <= fail_total;
  end

endmodule

FILE: test/tb_adc_ladder_key_decoder.sv
// Testbench top for adc_ladder_key_decoder: clock, reset, board register writes,
// directed and random sample streams with random stalls on both sides.
// Depends on alkd_pkg and adc_ladder_key_checker.
`timescale 1ns / 1ps

module tb_adc_ladder_key_decoder;
  import alkd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 260;

  localparam logic [0:1][0:NUM_LEVELS-1][SAMPLE_W-1:0] BAND_EDGE = {
    8'd92,  8'd72,  8'd52,  8'd33,  8'd12,  8'd0,
    8'd190, 8'd164, 8'd148, 8'd134, 8'd120, 8'd106
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] sample
  logic        s_axis_tuser = 1'b0; // [0] blanking
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] key_value, [8] clear_error, [9] locked
  int          pending;
  int          errors;
  int          cycle_count = 0;
  int unsigned sink_hold = 0;
  bit          quiet_tail = 1'b0;

  always #2 clk = ~clk;

  adc_ladder_key_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  adc_ladder_key_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending       (pending),
    .errors        (errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_adc_ladder_key_decoder failed");
      $finish;
    end
  end

  // stall the result side in bursts
  always @(posedge clk) begin
    if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(1, 19);
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold     <= 0;
    end
  end

  task automatic send(input logic [7:0] smp, input logic blank);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= blank;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold off until every request has its result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_board(input board_t b);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // band 0 releases; the last band of the second board lies below every threshold
  function automatic logic [7:0] band_sample(input board_t b, input int band);
    logic [7:0] lo;
    logic [7:0] hi;
    if (band == 0) begin
      lo = BAND_EDGE[b][0];
      hi = 8'd255;
    end else begin
      lo = (band < NUM_LEVELS) ? BAND_EDGE[b][band] : 8'd0;
      hi = BAND_EDGE[b][band-1] - 8'd1;
    end
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic press_key(input board_t b, inout int counted);
    int         band;
    int         len;
    logic [7:0] smp;
    logic       blank;
    if ($urandom_range(0, 4) == 0) begin
      smp   = 8'($urandom);
      blank = ($urandom_range(0, 3) == 0);
      send(smp, blank);
      counted++;
    end else begin
      band = $urandom_range(1, (b == BOARD_SECOND) ? NUM_LEVELS : NUM_LEVELS - 1);
      len  = $urandom_range(1, 7);
      repeat (len) begin
        blank = ($urandom_range(0, 9) == 0);
        smp   = blank ? 8'($urandom) : band_sample(b, band);
        send(smp, blank);
        counted++;
      end
      if ($urandom_range(0, 1) == 1) begin
        send(band_sample(b, 0), 1'b0);
        counted++;
      end
    end
  endtask

  initial begin : stimulus
    int     counted;
    board_t b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    settle();
    set_board(BOARD_FIRST);
    // first board: compound run, release, clear pulse, conflicting key, code zero
    repeat (5) send(8'd0, 1'b0);
    send(8'd255, 1'b1);
    send(8'd92, 1'b0);
    send(8'd91, 1'b0);
    send(8'd91, 1'b0);
    send(8'd60, 1'b0);
    send(8'd60, 1'b0);
    send(8'd20, 1'b0);
    send(8'd255, 1'b0);
    send(8'd12, 1'b0);
    send(8'd32, 1'b0);
    send(8'd33, 1'b0);
    settle();
    set_board(BOARD_SECOND);
    // second board: below ladder, code zero, compound count, release, clear count without pulse, key confirmed
    send(8'd105, 1'b0);
    send(8'd106, 1'b0);
    send(8'd106, 1'b0);
    send(8'd189, 1'b0);
    send(8'd164, 1'b0);
    send(8'd190, 1'b0);
    send(8'd148, 1'b0);
    send(8'd163, 1'b0);
    send(8'd147, 1'b0);
    send(8'd134, 1'b0);
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      b = (phase % 2 == 1) ? BOARD_SECOND : BOARD_FIRST;
      if (phase == 3) quiet_tail = 1'b1;
      set_board(b);
      counted = 0;
      while (counted < PHASE_ITEMS) press_key(b, counted);
    end
    settle();
    if (errors == 0) begin
      $display("tb_adc_ladder_key_decoder passed");
    end else begin
      $display("tb_adc_ladder_key_decoder failed");
    end
    $finish;
  end

endmodule
